FILE: rtl/arbu_pkg.sv
// shared types, constants and helpers for the audio ring buffer upsampler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package arbu_pkg;

  // default sizes
  localparam int DEF_RING_DEPTH    = 32768;
  localparam int DEF_CHUNK_SAMPLES = 256;

  // fixed field widths
  localparam int OP_W      = 2;
  localparam int SAMPLE_W  = 16;
  localparam int WORD_W    = 2 * SAMPLE_W;
  localparam int UNITS_W   = 15;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int RUN_W     = 4;
  localparam int SPOS_W    = 15;
  localparam int LWL_W     = 16;
  localparam int RUN_CNT_W = 3;

  localparam logic [RUN_W-1:0] MAX_RUN = 4'd8;
  localparam logic [RUN_W-1:0] MIN_RUN = 4'd1;

  // register reset values
  localparam logic [CFG_W-1:0]  RST_RING_LENGTH = 16'd19200;
  localparam logic [LWL_W-1:0]  RST_LOW_WATER   = 16'd4800;
  localparam logic [RUN_W-1:0]  RST_REPEAT      = 4'd1;
  localparam logic [RUN_W-1:0]  RST_FIRST_RUN   = 4'd1;
  localparam logic              RST_SYNC_EN     = 1'b0;
  localparam logic [SPOS_W-1:0] RST_SYNC_POS    = 15'd4608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RING_LENGTH = 3'd0,
    REG_LOW_WATER   = 3'd1,
    REG_REPEAT      = 3'd2,
    REG_FIRST_RUN   = 3'd3,
    REG_SYNC_EN     = 3'd4,
    REG_SYNC_POS    = 3'd5
  } cfg_reg_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_SYNC,
    S_READ,
    S_SUM,
    S_OCC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic write;
    logic sync;
    logic read;
    logic sum;
    logic occ;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic run_last;
    logic out_busy;
  } status_t;

  // out-of-range run lengths fold into 1..8
  function automatic logic [RUN_W-1:0] eff_run(input logic [RUN_W-1:0] r);
    logic [RUN_W-1:0] v;
    v = r;
    if (r == '0) begin
      v = MIN_RUN;
    end else if (r > MAX_RUN) begin
      v = MAX_RUN;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/audio_ring_buffer_upsampler_unit.sv
// top level of the stereo ring buffer with zero-order-hold upsampling
// depends on arbu_pkg, arbu_cfg, arbu_ctrl, arbu_dp
//
//   port group   direction  handshake            payload
//   in_          in         in_valid / in_stall   opcode, left, right, frame marks
//   out_         out        out_valid / out_stall left, right, units, low water
//   cfg_         in         cfg_we                cfg_index, cfg_wdata
//
// push writes 1 to 8 words on the single write port, then resyncs; pop reads the store,
// then unwraps and caps occupancy like query; one request in flight at a time
// after reset a clearing pass zeroes every store word while in_stall is held high
// a finished result waits in the output register while the next request is taken;
// the sequencer holds in its last step while out_stall keeps that register full
`timescale 1ns / 1ps
`default_nettype none

module audio_ring_buffer_upsampler_unit #(
  parameter int RING_DEPTH    = arbu_pkg::DEF_RING_DEPTH,
  parameter int CHUNK_SAMPLES = arbu_pkg::DEF_CHUNK_SAMPLES
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [arbu_pkg::OP_W-1:0]            in_opcode,
  input  wire logic signed [arbu_pkg::SAMPLE_W-1:0] in_left_in,
  input  wire logic signed [arbu_pkg::SAMPLE_W-1:0] in_right_in,
  input  wire logic                                in_frame_start,
  input  wire logic                                in_frame_end,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [arbu_pkg::SAMPLE_W-1:0]      out_left_out,
  output logic signed [arbu_pkg::SAMPLE_W-1:0]      out_right_out,
  output logic [arbu_pkg::UNITS_W-1:0]              out_buffered_units,
  output logic [arbu_pkg::UNITS_W-1:0]              out_free_units,
  output logic                                     out_low_water,
  input  wire logic                                cfg_we,
  input  wire logic [arbu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [arbu_pkg::CFG_W-1:0]           cfg_wdata
);
  import arbu_pkg::*;

  localparam int LEN_W = $clog2(RING_DEPTH + 1);

  cmd_t              cmd;
  status_t           status;
  logic [LEN_W-1:0]  len;
  logic [LWL_W-1:0]  low_water_lvl;
  logic [RUN_W-1:0]  repeat_runs;
  logic [RUN_W-1:0]  first_runs;
  logic              sync_en;
  logic [SPOS_W-1:0] sync_pos;

  arbu_cfg #(
    .RING_DEPTH (RING_DEPTH),
    .LEN_W      (LEN_W)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .len           (len),
    .low_water_lvl (low_water_lvl),
    .repeat_runs   (repeat_runs),
    .first_runs    (first_runs),
    .sync_en       (sync_en),
    .sync_pos      (sync_pos)
  );

  arbu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  arbu_dp #(
    .RING_DEPTH    (RING_DEPTH),
    .CHUNK_SAMPLES (CHUNK_SAMPLES),
    .LEN_W         (LEN_W)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_opcode          (in_opcode),
    .in_left_in         (in_left_in),
    .in_right_in        (in_right_in),
    .in_frame_start     (in_frame_start),
    .in_frame_end       (in_frame_end),
    .len                (len),
    .low_water_lvl      (low_water_lvl),
    .repeat_runs        (repeat_runs),
    .first_runs         (first_runs),
    .sync_en            (sync_en),
    .sync_pos           (sync_pos),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_out       (out_left_out),
    .out_right_out      (out_right_out),
    .out_buffered_units (out_buffered_units),
    .out_free_units     (out_free_units),
    .out_low_water      (out_low_water)
  );

endmodule

`default_nettype wire

FILE: rtl/arbu_cfg.sv
// configuration registers with range clamping of length and run counts
// depends on arbu_pkg
`timescale 1ns / 1ps
`default_nettype none

module arbu_cfg #(
  parameter int RING_DEPTH = arbu_pkg::DEF_RING_DEPTH,
  parameter int LEN_W      = $clog2(RING_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [arbu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [arbu_pkg::CFG_W-1:0]     cfg_wdata,
  output logic      [LEN_W-1:0]               len,
  output logic      [arbu_pkg::LWL_W-1:0]     low_water_lvl,
  output logic      [arbu_pkg::RUN_W-1:0]     repeat_runs,
  output logic      [arbu_pkg::RUN_W-1:0]     first_runs,
  output logic                                sync_en,
  output logic      [arbu_pkg::SPOS_W-1:0]    sync_pos
);
  import arbu_pkg::*;

  localparam int RL_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  logic [CFG_W-1:0]  ring_length_r;
  logic [LWL_W-1:0]  low_water_r;
  logic [RUN_W-1:0]  repeat_r;
  logic [RUN_W-1:0]  first_run_r;
  logic              sync_en_r;
  logic [SPOS_W-1:0] sync_pos_r;
  logic [RL_W-1:0]   rl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_length_r <= RST_RING_LENGTH;
      low_water_r   <= RST_LOW_WATER;
      repeat_r      <= RST_REPEAT;
      first_run_r   <= RST_FIRST_RUN;
      sync_en_r     <= RST_SYNC_EN;
      sync_pos_r    <= RST_SYNC_POS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_RING_LENGTH: ring_length_r <= cfg_wdata;
        REG_LOW_WATER:   low_water_r   <= cfg_wdata[LWL_W-1:0];
        REG_REPEAT:      repeat_r      <= cfg_wdata[RUN_W-1:0];
        REG_FIRST_RUN:   first_run_r   <= cfg_wdata[RUN_W-1:0];
        REG_SYNC_EN:     sync_en_r     <= cfg_wdata[0];
        REG_SYNC_POS:    sync_pos_r    <= cfg_wdata[SPOS_W-1:0];
        default: ;
      endcase
    end
  end

  // length clamped to 2..RING_DEPTH
  always_comb begin
    rl = RL_W'(ring_length_r);
    if (rl < RL_W'(2)) begin
      rl = RL_W'(2);
    end else if (rl > RL_W'(RING_DEPTH)) begin
      rl = RL_W'(RING_DEPTH);
    end
  end

  assign len           = LEN_W'(rl);
  assign low_water_lvl = low_water_r;
  assign repeat_runs   = eff_run(repeat_r);
  assign first_runs    = eff_run(first_run_r);
  assign sync_en       = sync_en_r;
  assign sync_pos      = sync_pos_r;

endmodule

`default_nettype wire

FILE: rtl/arbu_ctrl.sv
// sequencer: clearing pass, push run, pop and query steps, result hand-off
// depends on arbu_pkg
`timescale 1ns / 1ps
`default_nettype none

module arbu_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  input  wire logic [arbu_pkg::OP_W-1:0] in_opcode,
  output logic                          in_stall,
  input  wire arbu_pkg::status_t        status,
  output arbu_pkg::cmd_t                cmd
);
  import arbu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (op_t'(in_opcode))
            OP_PUSH:  state_nxt = S_WRITE;
            OP_POP:   state_nxt = S_READ;
            OP_QUERY: state_nxt = S_SUM;
            default:  state_nxt = S_DONE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        if (status.run_last) begin
          state_nxt = S_SYNC;
        end
      end
      S_SYNC: begin
        cmd.sync  = 1'b1;
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.read  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_OCC;
      end
      S_OCC: begin
        cmd.occ   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait until the output register can take the result
        if (!status.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/arbu_dp.sv
// datapath: sample store, pointers, run and chunk counters, occupancy, result register
// depends on arbu_pkg
`timescale 1ns / 1ps
`default_nettype none

module arbu_dp #(
  parameter int RING_DEPTH    = arbu_pkg::DEF_RING_DEPTH,
  parameter int CHUNK_SAMPLES = arbu_pkg::DEF_CHUNK_SAMPLES,
  parameter int LEN_W         = $clog2(RING_DEPTH + 1)
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire arbu_pkg::cmd_t                    cmd,
  output arbu_pkg::status_t                      status,
  input  wire logic [arbu_pkg::OP_W-1:0]          in_opcode,
  input  wire logic signed [arbu_pkg::SAMPLE_W-1:0] in_left_in,
  input  wire logic signed [arbu_pkg::SAMPLE_W-1:0] in_right_in,
  input  wire logic                              in_frame_start,
  input  wire logic                              in_frame_end,
  input  wire logic [LEN_W-1:0]                  len,
  input  wire logic [arbu_pkg::LWL_W-1:0]         low_water_lvl,
  input  wire logic [arbu_pkg::RUN_W-1:0]         repeat_runs,
  input  wire logic [arbu_pkg::RUN_W-1:0]         first_runs,
  input  wire logic                              sync_en,
  input  wire logic [arbu_pkg::SPOS_W-1:0]        sync_pos,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [arbu_pkg::SAMPLE_W-1:0]    out_left_out,
  output logic signed [arbu_pkg::SAMPLE_W-1:0]    out_right_out,
  output logic [arbu_pkg::UNITS_W-1:0]            out_buffered_units,
  output logic [arbu_pkg::UNITS_W-1:0]            out_free_units,
  output logic                                   out_low_water
);
  import arbu_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int SUM_W = LEN_W + 1;
  localparam int CC_W  = $clog2(CHUNK_SAMPLES);
  localparam int LWC_W = (LEN_W > LWL_W) ? LEN_W : LWL_W;
  localparam int SPC_W = (LEN_W > SPOS_W) ? LEN_W : SPOS_W;
  localparam int UX_W  = (LEN_W > UNITS_W) ? LEN_W : UNITS_W;

  logic [WORD_W-1:0] mem [RING_DEPTH];

  logic [OP_W-1:0]      op_r;
  logic [WORD_W-1:0]    word_r;
  logic                 frame_end_r;
  logic [RUN_W-1:0]     runs_r;
  logic [RUN_CNT_W-1:0] run_cnt_r;
  logic [PTR_W-1:0]     wp_r;
  logic [PTR_W-1:0]     rp_r;
  logic [PTR_W-1:0]     clr_r;
  logic [CC_W-1:0]      cc_r;
  logic                 hit_r;
  logic [SUM_W-1:0]     sum_r;
  logic [LEN_W-1:0]     occ_r;
  logic [WORD_W-1:0]    rd_data_r;
  logic                 out_valid_r;

  logic                 mem_we;
  logic [PTR_W-1:0]     mem_wa;
  logic [WORD_W-1:0]    mem_wd;
  logic [PTR_W-1:0]     wp_adv;
  logic [PTR_W-1:0]     rp_adv;
  logic [SUM_W-1:0]     diff;
  logic [LEN_W-1:0]     occ_nxt;
  logic                 sync_hit;
  logic [PTR_W-1:0]     sync_target;
  logic [LEN_W-1:0]     free_diff;
  logic [UX_W-1:0]      buf_ext;
  logic [UX_W-1:0]      free_ext;
  logic                 low_flag;

  // pointer advance with wrap at the effective length
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] q;
    q = LEN_W'(p) + LEN_W'(1);
    return (q >= n) ? '0 : PTR_W'(q);
  endfunction

  assign wp_adv = advance(wp_r, len);
  assign rp_adv = advance(rp_r, len);

  // store: one write port, registered read
  assign mem_we = cmd.clear | cmd.write;
  assign mem_wa = cmd.clear ? clr_r : wp_r;
  assign mem_wd = cmd.clear ? '0 : word_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.read) begin
      rd_data_r <= mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear) begin
      clr_r <= clr_r + PTR_W'(1);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= in_opcode;
      word_r      <= {in_right_in, in_left_in};
      frame_end_r <= in_frame_end;
      runs_r      <= in_frame_start ? first_runs : repeat_runs;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= '0;
    end else if (cmd.capture) begin
      run_cnt_r <= '0;
    end else if (cmd.write) begin
      run_cnt_r <= run_cnt_r + RUN_CNT_W'(1);
    end
  end

  // resync once the frame's last run is written, if enabled and the write pointer is at len/2
  assign sync_hit    = frame_end_r && sync_en && (LEN_W'(wp_r) == (len >> 1));
  assign sync_target = (SPC_W'(sync_pos) < SPC_W'(len)) ? PTR_W'(sync_pos) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cc_r  <= '0;
      hit_r <= 1'b0;
    end else begin
      if (cmd.write) begin
        wp_r <= wp_adv;
      end
      if (cmd.sync && sync_hit) begin
        rp_r <= sync_target;
      end else if (cmd.read) begin
        rp_r <= rp_adv;
      end
      if (cmd.read) begin
        hit_r <= (cc_r == CC_W'(CHUNK_SAMPLES - 1));
        cc_r  <= (cc_r == CC_W'(CHUNK_SAMPLES - 1)) ? '0 : cc_r + CC_W'(1);
      end
    end
  end

  // occupancy in two steps: unwrap, then subtract and cap
  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r <= (wp_r < rp_r) ? SUM_W'(wp_r) + SUM_W'(len) : SUM_W'(wp_r);
    end
  end

  assign diff    = (sum_r >= SUM_W'(rp_r)) ? sum_r - SUM_W'(rp_r) : '0;
  assign occ_nxt = (diff > SUM_W'(len)) ? len : LEN_W'(diff);

  always_ff @(posedge clk) begin
    if (cmd.occ) begin
      occ_r <= occ_nxt;
    end
  end

  assign free_diff = len - occ_r;
  assign buf_ext   = UX_W'(occ_r >> 1);
  assign free_ext  = UX_W'(free_diff >> 1);
  assign low_flag  = hit_r && (LWC_W'(occ_r) < LWC_W'(low_water_lvl));

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      unique case (op_t'(op_r))
        OP_POP: begin
          out_left_out       <= $signed(rd_data_r[SAMPLE_W-1:0]);
          out_right_out      <= $signed(rd_data_r[WORD_W-1:SAMPLE_W]);
          out_buffered_units <= '0;
          out_free_units     <= '0;
          out_low_water      <= low_flag;
        end
        OP_QUERY: begin
          out_left_out       <= '0;
          out_right_out      <= '0;
          out_buffered_units <= buf_ext[UNITS_W-1:0];
          out_free_units     <= free_ext[UNITS_W-1:0];
          out_low_water      <= 1'b0;
        end
        default: begin
          out_left_out       <= '0;
          out_right_out      <= '0;
          out_buffered_units <= '0;
          out_free_units     <= '0;
          out_low_water      <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;

  assign status.clear_done = (clr_r == PTR_W'(RING_DEPTH - 1));
  assign status.run_last   = ((RUN_W'(run_cnt_r) + RUN_W'(1)) == runs_r);
  assign status.out_busy   = out_valid_r && out_stall;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for audio_ring_buffer_upsampler_unit: push, pop, query and unknown
// opcode requests under random idling, checked against a cycle-free ring model in a scoreboard class
// depends on arbu_pkg and the rtl of the unit
`timescale 1ns / 1ps

module testbench;
  import arbu_pkg::*;

  localparam int unsigned RING_WORDS  = DEF_RING_DEPTH;
  localparam int unsigned CHUNK_POPS  = DEF_CHUNK_SAMPLES;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned PHASES      = 11;
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_s;
    logic [SAMPLE_W-1:0] right_s;
    logic [UNITS_W-1:0]  buffered_units;
    logic [UNITS_W-1:0]  free_units;
    logic                low_water;
  } ring_response_t;

  class ring_buffer_scoreboard;
    bit [WORD_W-1:0] ring_words [RING_WORDS];
    int unsigned ring_len_reg, low_level, rep_reg, first_reg, sync_on, sync_pos;
    int unsigned wr_ptr, rd_ptr, chunk_pops;
    ring_response_t due_responses[$];
    int unsigned mismatches;

    function new();
      ring_len_reg = RST_RING_LENGTH;
      low_level    = RST_LOW_WATER;
      rep_reg      = RST_REPEAT;
      first_reg    = RST_FIRST_RUN;
      sync_on      = RST_SYNC_EN;
      sync_pos     = RST_SYNC_POS;
      wr_ptr       = 0;
      rd_ptr       = 0;
      chunk_pops   = 0;
      mismatches   = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_RING_LENGTH: ring_len_reg = v;
        REG_LOW_WATER:   low_level = v;
        REG_REPEAT:      rep_reg = v[RUN_W-1:0];
        REG_FIRST_RUN:   first_reg = v[RUN_W-1:0];
        REG_SYNC_EN:     sync_on = v[0];
        REG_SYNC_POS:    sync_pos = v[SPOS_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned ring_len();
      if (ring_len_reg < 2) return 2;
      if (ring_len_reg > RING_WORDS) return RING_WORDS;
      return ring_len_reg;
    endfunction

    function int unsigned run_of(int unsigned r);
      if (r == 0) return 1;
      if (r > 8) return 8;
      return r;
    endfunction

    function int unsigned step_ptr(int unsigned p, int unsigned len);
      return (p + 1 >= len) ? 0 : p + 1;
    endfunction

    function int unsigned fill_level(int unsigned len);
      int unsigned wp, rp, occ;
      wp = wr_ptr;
      rp = rd_ptr;
      if (wp < rp) wp += len;
      occ = (wp >= rp) ? wp - rp : 0;
      if (occ > len) occ = len;
      return occ;
    endfunction

    function int unsigned pending();
      return due_responses.size();
    endfunction

    // runs the ring for one accepted request and queues its response
    function void predict_response(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] l,
                                   logic [SAMPLE_W-1:0] r, logic fs, logic fe);
      ring_response_t want;
      int unsigned len, runs, occ;
      bit [WORD_W-1:0] word;
      want = '0;
      len = ring_len();
      if (op == OP_PUSH) begin
        runs = fs ? run_of(first_reg) : run_of(rep_reg);
        for (int unsigned i = 0; i < runs; i++) begin
          ring_words[wr_ptr % RING_WORDS] = {r, l};
          wr_ptr = step_ptr(wr_ptr, len);
        end
        // frame end landing on half the ring pulls the read side back in step
        if (fe && sync_on != 0 && wr_ptr == (len >> 1)) begin
          rd_ptr = (sync_pos < len) ? sync_pos : 0;
        end
      end else if (op == OP_POP) begin
        word = ring_words[rd_ptr % RING_WORDS];
        want.left_s  = word[SAMPLE_W-1:0];
        want.right_s = word[WORD_W-1:SAMPLE_W];
        rd_ptr = step_ptr(rd_ptr, len);
        chunk_pops++;
        if (chunk_pops >= CHUNK_POPS) begin
          chunk_pops = 0;
          want.low_water = (fill_level(len) < low_level);
        end
      end else if (op == OP_QUERY) begin
        occ = fill_level(len);
        want.buffered_units = UNITS_W'(occ >> 1);
        want.free_units     = UNITS_W'((len - occ) >> 1);
      end
      due_responses.push_back(want);
    endfunction

    function void check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(ring_response_t got);
      ring_response_t want;
      if (due_responses.size() == 0) begin
        $error("response with no request outstanding: left %0d right %0d",
               $signed(got.left_s), $signed(got.right_s));
        mismatches++;
        return;
      end
      want = due_responses.pop_front();
      check_field("left_out", $signed(want.left_s), $signed(got.left_s));
      check_field("right_out", $signed(want.right_s), $signed(got.right_s));
      check_field("buffered_units", want.buffered_units, got.buffered_units);
      check_field("free_units", want.free_units, got.free_units);
      check_field("low_water", want.low_water, got.low_water);
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [OP_W-1:0]            in_opcode;
  logic signed [SAMPLE_W-1:0] in_left_in;
  logic signed [SAMPLE_W-1:0] in_right_in;
  logic                       in_frame_start;
  logic                       in_frame_end;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_left_out;
  logic signed [SAMPLE_W-1:0] out_right_out;
  logic [UNITS_W-1:0]         out_buffered_units;
  logic [UNITS_W-1:0]         out_free_units;
  logic                       out_low_water;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_W-1:0]           cfg_wdata;

  ring_buffer_scoreboard book = new();
  int unsigned hold_requests = 0;
  int unsigned frame_left = 0;

  audio_ring_buffer_upsampler_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_left_in        (in_left_in),
    .in_right_in       (in_right_in),
    .in_frame_start    (in_frame_start),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_out      (out_left_out),
    .out_right_out     (out_right_out),
    .out_buffered_units(out_buffered_units),
    .out_free_units    (out_free_units),
    .out_low_water     (out_low_water),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stall runs at a density that changes at random intervals, plus a held stall on request
  initial begin : result_backpressure
    int unsigned holds_served, stall_pct, mode_cycles, span;
    holds_served = 0;
    stall_pct = 0;
    mode_cycles = 0;
    forever begin
      if (hold_requests != holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_cycles == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
          mode_cycles = $urandom_range(100, 400);
        end
        span = $urandom_range(1, 8);
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        repeat (span) @(posedge clk);
        mode_cycles = (mode_cycles > span) ? mode_cycles - span : 0;
      end
    end
  end

  always @(posedge clk) begin
    ring_response_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.left_s         = out_left_out;
      seen.right_s        = out_right_out;
      seen.buffered_units = out_buffered_units;
      seen.free_units     = out_free_units;
      seen.low_water      = out_low_water;
      book.check_response(seen);
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [SAMPLE_W-1:0] l,
                              logic [SAMPLE_W-1:0] r, logic fs, logic fe);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_left_in     <= l;
    in_right_in    <= r;
    in_frame_start <= fs;
    in_frame_end   <= fe;
    do @(posedge clk); while (in_stall !== 1'b0);
    book.predict_response(op, l, r, fs, fe);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    book.set_reg(idx, v);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] len_v, logic [CFG_W-1:0] lw_v,
                              logic [CFG_W-1:0] rep_v, logic [CFG_W-1:0] first_v,
                              logic [CFG_W-1:0] sync_v, logic [CFG_W-1:0] spos_v);
    write_reg(REG_RING_LENGTH, len_v);
    write_reg(REG_LOW_WATER, lw_v);
    write_reg(REG_REPEAT, rep_v);
    write_reg(REG_FIRST_RUN, first_v);
    write_reg(REG_SYNC_EN, sync_v);
    write_reg(REG_SYNC_POS, spos_v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly short rings so pointers wrap and resync hits are common
  task automatic randomize_regs();
    logic [CFG_W-1:0] len_v, lw_v, spos_v;
    int unsigned eff;
    case ($urandom_range(0, 9))
      0: len_v = CFG_W'($urandom_range(0, 1));
      1: len_v = CFG_W'(RING_WORDS);
      2: len_v = CFG_W'($urandom_range(RING_WORDS + 1, 65535));
      3, 4: len_v = CFG_W'($urandom_range(2, RING_WORDS));
      default: len_v = CFG_W'($urandom_range(2, 40));
    endcase
    eff = (len_v < 2) ? 2 : ((len_v > RING_WORDS) ? RING_WORDS : len_v);
    lw_v = CFG_W'(($urandom_range(0, 4) == 0) ? $urandom()
                                               : $urandom_range(0, eff + eff / 2));
    spos_v = CFG_W'(($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, eff - 1));
    program_regs(len_v, lw_v, CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)),
                 CFG_W'($urandom_range(0, 9) < 7), spos_v);
  endtask

  // pushes mostly come as framed runs, with some stray marks mixed in
  task automatic next_request(int unsigned pop_pct, output logic [OP_W-1:0] op,
                              output logic [SAMPLE_W-1:0] l, output logic [SAMPLE_W-1:0] r,
                              output logic fs, output logic fe);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    l = SAMPLE_W'($urandom());
    r = SAMPLE_W'($urandom());
    fs = 1'b0;
    fe = 1'b0;
    if (pick < pop_pct) begin
      op = OP_POP;
    end else if (pick < pop_pct + 10) begin
      op = OP_QUERY;
    end else if (pick < pop_pct + 13) begin
      op = OP_UNKNOWN;
      fs = ($urandom_range(0, 1) != 0);
      fe = ($urandom_range(0, 1) != 0);
    end else begin
      op = OP_PUSH;
      if ($urandom_range(0, 9) == 0) begin
        fs = ($urandom_range(0, 1) != 0);
        fe = ($urandom_range(0, 1) != 0);
      end else begin
        if (frame_left == 0) begin
          frame_left = $urandom_range(1, 6);
          fs = 1'b1;
        end
        frame_left--;
        fe = (frame_left == 0);
      end
    end
  endtask

  task automatic run_random(int unsigned count, int unsigned pop_pct, bit with_hold);
    int unsigned burst, gap;
    logic [OP_W-1:0] op;
    logic [SAMPLE_W-1:0] l, r;
    logic fs, fe;
    burst = 0;
    for (int unsigned k = 0; k < count; k++) begin
      if (burst == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 24);
      end
      burst--;
      // receiver freezes while requests keep coming so the unit backs up
      if (with_hold && k == 30) hold_requests <= hold_requests + 1;
      next_request(pop_pct, op, l, r, fs, fe);
      send_request(op, l, r, fs, fe);
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_opcode      <= OP_PUSH;
    in_left_in     <= '0;
    in_right_in    <= '0;
    in_frame_start <= 1'b0;
    in_frame_end   <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_RING_LENGTH;
    cfg_wdata      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: sample extremes, frame marks, reads past the written data
    send_request(OP_QUERY, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(OP_PUSH, 16'h8000, 16'h7fff, 1'b1, 1'b0);
    send_request(OP_PUSH, 16'h7fff, 16'h8000, 1'b0, 1'b1);
    send_request(OP_PUSH, 16'hffff, 16'h0000, 1'b1, 1'b1);
    send_request(OP_PUSH, 16'h0000, 16'hffff, 1'b0, 1'b0);
    repeat (5) send_request(OP_POP, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(OP_QUERY, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(OP_UNKNOWN, SAMPLE_W'($urandom()), SAMPLE_W'($urandom()), 1'b1, 1'b1);
    send_request(OP_UNKNOWN, 16'h0000, 16'h0000, 1'b0, 1'b0);
    wait_for_drain();

    // length below minimum with pointers left beyond it, zero repeat, oversized first run,
    // resync target out of range
    program_regs(16'd0, 16'hffff, 16'd0, 16'd15, 16'd1, 16'h7fff);
    send_request(OP_PUSH, 16'h1234, 16'hedcb, 1'b1, 1'b1);
    send_request(OP_QUERY, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(OP_POP, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(OP_POP, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(OP_PUSH, 16'h5555, 16'haaaa, 1'b0, 1'b1);
    send_request(OP_QUERY, 16'h0000, 16'h0000, 1'b0, 1'b0);
    wait_for_drain();

    // length above the store, zero first run, oversized repeat
    program_regs(16'hffff, 16'd0, 16'd15, 16'd0, 16'd1, 16'd100);
    send_request(OP_PUSH, 16'haaaa, 16'h5555, 1'b1, 1'b0);
    send_request(OP_PUSH, 16'h0001, 16'h8001, 1'b0, 1'b1);
    send_request(OP_QUERY, 16'h0000, 16'h0000, 1'b0, 1'b0);
    send_request(OP_POP, 16'h0000, 16'h0000, 1'b0, 1'b0);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_for_drain();
      randomize_regs();
      run_random(160, (ph == 5) ? 80 : $urandom_range(25, 50), ph == 2);
    end
    wait_for_drain();

    if (book.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/arbu_pkg.sv
rtl/arbu_cfg.sv
rtl/arbu_ctrl.sv
rtl/arbu_dp.sv
rtl/audio_ring_buffer_upsampler_unit.sv
tb/testbench.sv
